// ===== hw/rtl/ctd_pkg.sv =====
// shared types and constants of the capacitive touch detector
package ctd_pkg;

  localparam int SampleW   = 8;
  localparam int SumW      = 12;
  localparam int CountW    = 4;
  localparam int BaseW     = 16;
  localparam int TimerW    = 8;
  localparam int DeltaW    = 13;
  localparam int StatusW   = 3;
  localparam int AddrW     = 4;
  localparam int DataW     = 32;

  // samples per group, fixed so that a full group fits the 12-bit sum
  localparam int GroupSize = 16;
  localparam logic [CountW-1:0] GroupLast = CountW'(GroupSize - 1);
  localparam logic [TimerW-1:0] TimeoutLimit = TimerW'(255);

  // item operations
  localparam logic OpSeed    = 1'b0;
  localparam logic OpMeasure = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] StOff     = 3'd0;
  localparam logic [StatusW-1:0] StPush    = 3'd1;
  localparam logic [StatusW-1:0] StOn      = 3'd2;
  localparam logic [StatusW-1:0] StRelease = 3'd3;
  localparam logic [StatusW-1:0] StTimeout = 3'd4;

  // register indexes (word address bits)
  localparam logic [1:0] RegThresholdOn  = 2'd0;
  localparam logic [1:0] RegThresholdOff = 2'd1;
  localparam logic [1:0] RegTimeoutEn    = 2'd2;

  localparam logic signed [DeltaW-1:0] ThresholdOnReset  = 13'sd20;
  localparam logic signed [DeltaW-1:0] ThresholdOffReset = 13'sd10;

  typedef struct packed {
    logic signed [DeltaW-1:0] threshold_on;
    logic signed [DeltaW-1:0] threshold_off;
    logic                     timeout_enable;
  } cfg_t;

  typedef struct packed {
    logic                     valid;
    logic [StatusW-1:0]       status;
    logic signed [DeltaW-1:0] delta;
  } result_t;

endpackage

// ===== hw/rtl/ctd_if.sv =====
// valid/ready channel interfaces for samples and results
interface ctd_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [ctd_pkg::SampleW-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink (input valid, input op, input sample, output ready);
endinterface

interface ctd_out_if;
  logic                              valid;
  logic                              ready;
  logic [ctd_pkg::StatusW-1:0]       status;
  logic signed [ctd_pkg::DeltaW-1:0] delta;

  modport source (output valid, output status, output delta, input ready);
  modport sink (input valid, input status, input delta, output ready);
endinterface

// ===== hw/rtl/ctd_cfg_regs.sv =====
// apb register file holding thresholds and timeout enable
module ctd_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ctd_pkg::AddrW-1:0]   paddr,
  input  logic [ctd_pkg::DataW-1:0]   pwdata,
  output logic [ctd_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output ctd_pkg::cfg_t               cfg
);

  ctd_pkg::cfg_t regs;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.threshold_on   <= ctd_pkg::ThresholdOnReset;
      regs.threshold_off  <= ctd_pkg::ThresholdOffReset;
      regs.timeout_enable <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        ctd_pkg::RegThresholdOn:  regs.threshold_on   <= pwdata[ctd_pkg::DeltaW-1:0];
        ctd_pkg::RegThresholdOff: regs.threshold_off  <= pwdata[ctd_pkg::DeltaW-1:0];
        ctd_pkg::RegTimeoutEn:    regs.timeout_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ctd_pkg::RegThresholdOn:
        prdata = ctd_pkg::DataW'(regs.threshold_on);
      ctd_pkg::RegThresholdOff:
        prdata = ctd_pkg::DataW'(regs.threshold_off);
      ctd_pkg::RegTimeoutEn:
        prdata = {{(ctd_pkg::DataW-1){1'b0}}, regs.timeout_enable};
      default:
        prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/ctd_core.sv =====
// detector state and per-sample update logic
module ctd_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          op,
  input  logic [ctd_pkg::SampleW-1:0]   sample,
  input  ctd_pkg::cfg_t                 cfg,
  output ctd_pkg::result_t              result
);

  logic [ctd_pkg::BaseW-1:0]  baseline, baseline_next;
  logic                       touched, touched_next;
  logic [ctd_pkg::TimerW-1:0] hold_timer, hold_timer_next;
  logic [ctd_pkg::SumW-1:0]   group_sum, group_sum_next;
  logic [ctd_pkg::CountW-1:0] group_count, group_count_next;
  logic                       reseed_pending, reseed_pending_next;

  logic [ctd_pkg::SumW-1:0]          sum_acc;
  logic signed [ctd_pkg::DeltaW-1:0] delta_c;
  logic [ctd_pkg::BaseW-1:0]         seed_base;
  logic [ctd_pkg::BaseW-1:0]         iir_base;

  assign sum_acc   = group_sum + ctd_pkg::SumW'(sample);
  assign delta_c   = $signed({1'b0, sum_acc}) - $signed({1'b0, baseline[15:4]});
  assign seed_base = {sample, 8'd0};
  // baseline += sum/4 - baseline/64, wrapping at 16 bits
  assign iir_base  = baseline - {6'd0, baseline[15:6]} + {6'd0, sum_acc[11:2]};

  always_comb begin
    baseline_next       = baseline;
    touched_next        = touched;
    hold_timer_next     = hold_timer;
    group_sum_next      = group_sum;
    group_count_next    = group_count;
    reseed_pending_next = reseed_pending;
    result.valid        = 1'b0;
    result.status       = ctd_pkg::StOff;
    result.delta        = delta_c;

    if (op == ctd_pkg::OpSeed) begin
      baseline_next       = seed_base;
      touched_next        = 1'b0;
      group_sum_next      = '0;
      group_count_next    = '0;
      reseed_pending_next = 1'b0;
    end else if (reseed_pending) begin
      baseline_next       = seed_base;
      reseed_pending_next = 1'b0;
      result.valid        = 1'b1;
      result.status       = ctd_pkg::StTimeout;
      result.delta        = '0;
    end else if (group_count != ctd_pkg::GroupLast) begin
      group_sum_next   = sum_acc;
      group_count_next = group_count + 1'b1;
    end else begin
      group_sum_next   = '0;
      group_count_next = '0;
      if (!touched) begin
        result.valid = 1'b1;
        if (delta_c > cfg.threshold_on) begin
          touched_next    = 1'b1;
          hold_timer_next = '0;
          result.status   = ctd_pkg::StPush;
        end else begin
          baseline_next = iir_base;
          result.status = ctd_pkg::StOff;
        end
      end else if (delta_c < cfg.threshold_off) begin
        touched_next  = 1'b0;
        result.valid  = 1'b1;
        result.status = ctd_pkg::StRelease;
      end else if (cfg.timeout_enable && hold_timer == ctd_pkg::TimeoutLimit) begin
        reseed_pending_next = 1'b1;
      end else begin
        hold_timer_next = hold_timer + 1'b1;
        result.valid    = 1'b1;
        result.status   = ctd_pkg::StOn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline       <= '0;
      touched        <= 1'b0;
      hold_timer     <= '0;
      group_sum      <= '0;
      group_count    <= '0;
      reseed_pending <= 1'b0;
    end else if (step) begin
      baseline       <= baseline_next;
      touched        <= touched_next;
      hold_timer     <= hold_timer_next;
      group_sum      <= group_sum_next;
      group_count    <= group_count_next;
      reseed_pending <= reseed_pending_next;
    end
  end

endmodule

// ===== hw/rtl/cap_touch_detector.sv =====
// top level of the capacitive touch detector: pipeline registers and config
//
// channel     dir  fields           meaning
// sample_ch   in   op, sample       seed or measurement sample
// result_ch   out  status, delta    one result per completed group or reseed
// apb         in   thresholds, en   register writes and reads
//
// one item per cycle sustained while no result is stalled; the result is registered
// twice after the sample transfer
// (input register, then the state update writes the result register)
// synchronous reset clears the state, thresholds go to 20 and 10, timeout on
// a stalled result holds the input register; items that make no result
// still pass through it without waiting on the output side
module cap_touch_detector (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ctd_pkg::AddrW-1:0]   paddr,
  input  logic [ctd_pkg::DataW-1:0]   pwdata,
  output logic [ctd_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  ctd_in_if.sink                      sample_ch,
  ctd_out_if.source                   result_ch
);

  ctd_pkg::cfg_t    cfg;
  ctd_pkg::result_t core_res;

  // input register
  logic                         in_valid;
  logic                         in_op;
  logic [ctd_pkg::SampleW-1:0]  in_sample;

  // output register
  logic                              out_valid;
  logic [ctd_pkg::StatusW-1:0]       out_status;
  logic signed [ctd_pkg::DeltaW-1:0] out_delta;

  logic out_free;
  logic step;

  ctd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // result register can take a new value this cycle
  assign out_free = !out_valid || result_ch.ready;
  // the held item updates state and moves on; only a result needs a free slot
  assign step = in_valid && (out_free || !core_res.valid);

  assign sample_ch.ready = !in_valid || step;

  ctd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .op     (in_op),
    .sample (in_sample),
    .cfg    (cfg),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample_ch.ready) begin
      in_valid <= sample_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ch.valid && sample_ch.ready) begin
      in_op     <= sample_ch.op;
      in_sample <= sample_ch.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && core_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && core_res.valid) begin
      out_status <= core_res.status;
      out_delta  <= core_res.delta;
    end
  end

  assign result_ch.valid  = out_valid;
  assign result_ch.status = out_status;
  assign result_ch.delta  = out_delta;

  // a timeout result always carries a zero delta
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ctd_pkg::StTimeout |-> out_delta == '0)
    else $error("timeout result with nonzero delta");

  // push only above the on threshold
  a_push_thr: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ctd_pkg::StPush |-> out_delta > cfg.threshold_on)
    else $error("push result not above threshold_on");

  // release only below the off threshold
  a_release_thr: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ctd_pkg::StRelease |-> out_delta < cfg.threshold_off)
    else $error("release result not below threshold_off");

  // a stalled result is held until it is taken; it blocks the held item only when that item has a result of its own
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_ch.ready |=> out_valid)
    else $error("pending result dropped");

endmodule
